[hw/rtl/hcrpc_pkg.sv]
`timescale 1ns / 1ps

package hcrpc_pkg;

  // Frame geometry and detection limit.
  localparam int FrameWidth      = 640;
  localparam int DetectThreshold = 10000;

  localparam int ColorW = 8;
  localparam int CoordW = 10;
  localparam int CountW = 19;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 10;

  localparam logic [CountW-1:0] TallyMax = '1;

  // Fixed-point scale of the reciprocal tables.
  localparam int FixShift = 12;
  localparam int SdivW = 20;
  localparam int HdivW = 17;

  // Depth of the queue between classifier and tally.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HUE_LOW        = 4'd0,
    CFG_HUE_HIGH       = 4'd1,
    CFG_SATURATION_LOW = 4'd2,
    CFG_VALUE_LOW      = 4'd3,
    CFG_REGION_LEFT    = 4'd4,
    CFG_REGION_RIGHT   = 4'd5,
    CFG_REGION_TOP     = 4'd6,
    CFG_REGION_BOTTOM  = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [ColorW-1:0] hue_low;
    logic [ColorW-1:0] hue_high;
    logic [ColorW-1:0] saturation_low;
    logic [ColorW-1:0] value_low;
    logic [CoordW-1:0] region_left;
    logic [CoordW-1:0] region_right;
    logic [CoordW-1:0] region_top;
    logic [CoordW-1:0] region_bottom;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    hue_low:        8'd95,
    hue_high:       8'd105,
    saturation_low: 8'd50,
    value_low:      8'd50,
    region_left:    10'd200,
    region_right:   10'd400,
    region_top:     10'd50,
    region_bottom:  10'd230
  };

  typedef struct packed {
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
    logic              frame_end;
  } pix_t;

  // One classified pixel as it travels from the front to the tally.
  typedef struct packed {
    logic hit;
    logic last;
  } tok_t;

  typedef logic [SdivW-1:0] sdiv_tab_t [256];
  typedef logic [HdivW-1:0] hdiv_tab_t [256];

  // Quotient of two constants by shift and subtract, used only to build the tables.
  function automatic int unsigned const_quot(input int unsigned num, input int unsigned den);
    int unsigned rem;
    int unsigned quo;
    rem = '0;
    quo = '0;
    for (int k = 31; k >= 0; k--) begin
      rem = {rem[30:0], num[k]};
      quo = {quo[30:0], 1'b0};
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Saturation reciprocal: round(255 * 4096 / v), zero for v = 0.
  function automatic sdiv_tab_t build_sdiv_tab();
    sdiv_tab_t t;
    t[0] = '0;
    for (int i = 1; i < 256; i++) begin
      t[i] = SdivW'(const_quot(unsigned'(2 * (255 << FixShift) + i), unsigned'(2 * i)));
    end
    return t;
  endfunction

  // Hue reciprocal: round(180 * 4096 / (6 * diff)), zero for diff = 0.
  function automatic hdiv_tab_t build_hdiv_tab();
    hdiv_tab_t t;
    t[0] = '0;
    for (int i = 1; i < 256; i++) begin
      t[i] = HdivW'(const_quot(unsigned'(2 * (180 << FixShift) + 6 * i),
                               unsigned'(12 * i)));
    end
    return t;
  endfunction

  localparam sdiv_tab_t SdivTab = build_sdiv_tab();
  localparam hdiv_tab_t HdivTab = build_hdiv_tab();

endpackage

[hw/rtl/hcrpc_if.sv]
`timescale 1ns / 1ps

// Pixel stream channel.
interface hcrpc_pix_if;
  logic                            valid;
  logic                            ready;
  logic [hcrpc_pkg::ColorW-1:0]    blue;
  logic [hcrpc_pkg::ColorW-1:0]    green;
  logic [hcrpc_pkg::ColorW-1:0]    red;
  logic                            frame_end;

  modport source (output valid, blue, green, red, frame_end, input ready);
  modport sink   (input valid, blue, green, red, frame_end, output ready);
endinterface

// Per-frame result channel.
interface hcrpc_res_if;
  logic                            valid;
  logic                            ready;
  logic [hcrpc_pkg::CountW-1:0]    match_count;
  logic                            detected;

  modport source (output valid, match_count, detected, input ready);
  modport sink   (input valid, match_count, detected, output ready);
endinterface

// Register write channel.
interface hcrpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hcrpc_pkg::CfgIdxW-1:0]   index;
  logic [hcrpc_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/hcrpc_front.sv]
`timescale 1ns / 1ps

module hcrpc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcrpc_pkg::cfg_t   cfg_i,
  input  logic              pix_valid_i,
  output logic              pix_ready_o,
  input  hcrpc_pkg::pix_t   pix_i,
  output logic              tok_valid_o,
  input  logic              tok_ready_i,
  output hcrpc_pkg::tok_t   tok_o
);

  localparam int CW = hcrpc_pkg::CoordW;
  localparam int PW = hcrpc_pkg::ColorW;

  logic adv;
  logic accept;

  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;

  // Stage valid bits.
  logic va_q, vb_q, vc_q, vd_q;

  // Stage A: raw pixel plus region test.
  logic [PW-1:0] a_b_q, a_g_q, a_r_q;
  logic          a_last_q, a_ok_q;
  logic          region_ok;

  // Stage B: max, spread and hue numerator.
  logic [PW-1:0] b_v_q, b_diff_q;
  logic [11:0]   b_hnum_q;
  logic          b_last_q, b_ok_q;
  logic [PW-1:0] vmax, vmin, diff;
  logic [11:0]   hnum;

  // Stage C: reciprocals.
  logic [PW-1:0]                 c_v_q, c_diff_q;
  logic [11:0]                   c_hnum_q;
  logic [hcrpc_pkg::SdivW-1:0]   c_sdiv_q;
  logic [hcrpc_pkg::HdivW-1:0]   c_hdiv_q;
  logic                          c_last_q, c_ok_q;

  // Stage D: products.
  logic [PW-1:0]      d_v_q;
  logic [27:0]        d_sprod_q, sprod;
  logic signed [29:0] d_hprod_q, hprod;
  logic               d_last_q, d_ok_q;

  // Final rounding and threshold compare.
  logic [27:0]        ssum;
  logic [15:0]        sat;
  logic signed [29:0] hsum;
  logic signed [29:0] hshift;
  logic [9:0]         hue_raw;
  logic [9:0]         hue_adj;
  logic [PW-1:0]      hue;

  // The whole pipe moves unless its last stage holds a word the queue refuses.
  assign adv         = !vd_q || tok_ready_i;
  assign pix_ready_o = adv;
  assign accept      = pix_valid_i && adv;

  // Raster position of the pixel being accepted.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_i.frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if ({1'b0, col_q} + (CW+1)'(1) >= (CW+1)'(hcrpc_pkg::FrameWidth)) begin
      col_d = '0;
      row_d = row_q + CW'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  assign region_ok = (col_q >= cfg_i.region_left) && (col_q <= cfg_i.region_right) &&
                     (row_q >= cfg_i.region_top) && (row_q <= cfg_i.region_bottom);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      vc_q  <= 1'b0;
      vd_q  <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (adv) begin
        va_q <= pix_valid_i;
        vb_q <= va_q;
        vc_q <= vb_q;
        vd_q <= vc_q;
      end
    end
  end

  // Max, min and the hue numerator for the sector that holds the max.
  always_comb begin
    vmax = a_b_q;
    vmin = a_b_q;
    if (a_g_q > vmax) vmax = a_g_q;
    if (a_r_q > vmax) vmax = a_r_q;
    if (a_g_q < vmin) vmin = a_g_q;
    if (a_r_q < vmin) vmin = a_r_q;
    diff = vmax - vmin;
    priority if (vmax == a_r_q) begin
      hnum = {4'b0, a_g_q} - {4'b0, a_b_q};
    end else if (vmax == a_g_q) begin
      hnum = {4'b0, a_b_q} - {4'b0, a_r_q} + {3'b0, diff, 1'b0};
    end else begin
      hnum = {4'b0, a_r_q} - {4'b0, a_g_q} + {2'b0, diff, 2'b0};
    end
  end

  assign sprod = 28'(c_diff_q) * 28'(c_sdiv_q);
  assign hprod = $signed({{18{c_hnum_q[11]}}, c_hnum_q}) *
                 $signed({13'b0, c_hdiv_q});

  // Payload registers of all stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_b_q    <= pix_i.blue;
      a_g_q    <= pix_i.green;
      a_r_q    <= pix_i.red;
      a_last_q <= pix_i.frame_end;
      a_ok_q   <= region_ok;

      b_v_q    <= vmax;
      b_diff_q <= diff;
      b_hnum_q <= hnum;
      b_last_q <= a_last_q;
      b_ok_q   <= a_ok_q;

      c_v_q    <= b_v_q;
      c_diff_q <= b_diff_q;
      c_hnum_q <= b_hnum_q;
      c_sdiv_q <= hcrpc_pkg::SdivTab[b_v_q];
      c_hdiv_q <= hcrpc_pkg::HdivTab[b_diff_q];
      c_last_q <= b_last_q;
      c_ok_q   <= b_ok_q;

      d_v_q     <= c_v_q;
      d_sprod_q <= sprod;
      d_hprod_q <= hprod;
      d_last_q  <= c_last_q;
      d_ok_q    <= c_ok_q;
    end
  end

  // Round to nearest, floor for negative hue, then wrap it into range.
  always_comb begin
    ssum    = d_sprod_q + 28'd2048;
    sat     = ssum[27:12];
    hsum    = d_hprod_q + 30'sd2048;
    hshift  = hsum >>> hcrpc_pkg::FixShift;
    hue_raw = hshift[9:0];
    hue_adj = hue_raw[9] ? hue_raw + 10'd180 : hue_raw;
    hue     = hue_adj[7:0];
  end

  assign tok_valid_o = vd_q;
  assign tok_o.last  = d_last_q;
  assign tok_o.hit   = d_ok_q &&
                       (hue >= cfg_i.hue_low) && (hue <= cfg_i.hue_high) &&
                       (sat >= {8'b0, cfg_i.saturation_low}) &&
                       (d_v_q >= cfg_i.value_low);

endmodule

[hw/rtl/hcrpc_queue.sv]
`timescale 1ns / 1ps

module hcrpc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  hcrpc_pkg::tok_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output hcrpc_pkg::tok_t pop_data_o
);

  localparam int AW = hcrpc_pkg::QueuePtrW;

  hcrpc_pkg::tok_t    slot_q [hcrpc_pkg::QueueDepth];
  logic [AW-1:0]      wptr_q, rptr_q;
  logic [AW:0]        count_q;
  logic               push, pop;

  assign push_ready_o = count_q != (AW+1)'(hcrpc_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers wrap on their own width; the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + AW'(1);
      if (pop)  rptr_q <= rptr_q + AW'(1);
      if (push && !pop) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

endmodule

[hw/rtl/hcrpc_back.sv]
`timescale 1ns / 1ps

module hcrpc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           tok_valid_i,
  output logic                           tok_ready_o,
  input  hcrpc_pkg::tok_t                tok_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [hcrpc_pkg::CountW-1:0]   res_count_o,
  output logic                           res_detected_o
);

  localparam int NW = hcrpc_pkg::CountW;

  logic [NW-1:0] tally_q, tally_d, tally_next;
  logic          res_valid_q;
  logic [NW-1:0] res_count_q;
  logic          res_detected_q;
  logic          take;

  // A frame-end word waits while the previous result is still unclaimed.
  assign tok_ready_o = !tok_i.last || !res_valid_q || res_ready_i;
  assign take        = tok_valid_i && tok_ready_o;

  assign tally_next = (tok_i.hit && tally_q != hcrpc_pkg::TallyMax) ?
                      tally_q + NW'(1) : tally_q;

  always_comb begin
    tally_d = tally_q;
    if (take) begin
      tally_d = tok_i.last ? '0 : tally_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      tally_q <= tally_d;
      if (take && tok_i.last) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result word for the frame that just closed.
  always_ff @(posedge clk_i) begin
    if (take && tok_i.last) begin
      res_count_q    <= tally_next;
      res_detected_q <= tally_next >= NW'(hcrpc_pkg::DetectThreshold);
    end
  end

  assign res_valid_o    = res_valid_q;
  assign res_count_o    = res_count_q;
  assign res_detected_o = res_detected_q;

endmodule

[hw/rtl/hsv_color_roi_pixel_counter_unit.sv]
`timescale 1ns / 1ps

// Channel   Dir  Word fields
// pix_i     in   blue[7:0], green[7:0], red[7:0], frame_end
// res_o     out  match_count[18:0], detected
// cfg_i     in   index[3:0], data[9:0]
//
// One pixel word is taken per clock when nothing downstream stalls; the
// four-stage color conversion pipe in the front sets the latency, not the rate.
// A result word is registered once its frame-end pixel has left the pipe and the queue.
// Reset clears the raster position, the tally and the queue, and loads the
// default bounds. A four-word queue separates classification from the tally,
// and the result register holds a frame's word until it is taken.

module hsv_color_roi_pixel_counter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcrpc_pix_if.sink   pix_i,
  hcrpc_cfg_if.sink   cfg_i,
  hcrpc_res_if.source res_o
);

  hcrpc_pkg::cfg_t cfg_q;
  hcrpc_pkg::pix_t pix;
  hcrpc_pkg::tok_t front_tok, head_tok;
  logic            front_valid, front_ready;
  logic            head_valid, head_ready;

  // Register writes; an index beyond the list is ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= hcrpc_pkg::CfgReset;
    end else if (cfg_i.valid) begin
      unique case (hcrpc_pkg::cfg_idx_e'(cfg_i.index))
        hcrpc_pkg::CFG_HUE_LOW:        cfg_q.hue_low        <= cfg_i.data[7:0];
        hcrpc_pkg::CFG_HUE_HIGH:       cfg_q.hue_high       <= cfg_i.data[7:0];
        hcrpc_pkg::CFG_SATURATION_LOW: cfg_q.saturation_low <= cfg_i.data[7:0];
        hcrpc_pkg::CFG_VALUE_LOW:      cfg_q.value_low      <= cfg_i.data[7:0];
        hcrpc_pkg::CFG_REGION_LEFT:    cfg_q.region_left    <= cfg_i.data;
        hcrpc_pkg::CFG_REGION_RIGHT:   cfg_q.region_right   <= cfg_i.data;
        hcrpc_pkg::CFG_REGION_TOP:     cfg_q.region_top     <= cfg_i.data;
        hcrpc_pkg::CFG_REGION_BOTTOM:  cfg_q.region_bottom  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign pix.blue      = pix_i.blue;
  assign pix.green     = pix_i.green;
  assign pix.red       = pix_i.red;
  assign pix.frame_end = pix_i.frame_end;

  hcrpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_i.ready),
    .pix_i       (pix),
    .tok_valid_o (front_valid),
    .tok_ready_i (front_ready),
    .tok_o       (front_tok)
  );

  hcrpc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_tok),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_data_o   (head_tok)
  );

  hcrpc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tok_valid_i    (head_valid),
    .tok_ready_o    (head_ready),
    .tok_i          (head_tok),
    .res_valid_o    (res_o.valid),
    .res_ready_i    (res_o.ready),
    .res_count_o    (res_o.match_count),
    .res_detected_o (res_o.detected)
  );

  // A classified word refused by the queue is still offered next cycle.
  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_valid && !front_ready) |=> front_valid)
    else $error("front dropped a stalled word");

  // A frame end never overwrites an unclaimed result.
  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready && head_valid && head_tok.last) |-> !head_ready)
    else $error("result overwritten before it was taken");

  // The detect flag agrees with the count it goes with.
  a_detect_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |->
      (res_o.detected ==
       (res_o.match_count >= hcrpc_pkg::CountW'(hcrpc_pkg::DetectThreshold))))
    else $error("detected flag disagrees with match count");

  // Pixels stall at the input only while the queue refuses an offered word.
  a_stall_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pix_i.ready) |-> (front_valid && !front_ready))
    else $error("input stalled without a queue stall");

endmodule

[tb/tb_hsv_color_roi_pixel_counter_unit.sv]
`timescale 1ns / 1ps

module tb_hsv_color_roi_pixel_counter_unit;

  localparam int SettleCycles   = 24;
  localparam int FirstUnusedIdx = int'(hcrpc_pkg::CFG_REGION_BOTTOM) + 1;
  localparam int RandomPhases   = 21;

  typedef struct packed {
    logic [hcrpc_pkg::CountW-1:0] match_count;
    logic                         detected;
  } frame_result_t;

  logic clk_i;
  logic rst_ni;

  hcrpc_pix_if pix ();
  hcrpc_cfg_if cfg ();
  hcrpc_res_if res ();

  hsv_color_roi_pixel_counter_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Shadow copy of the register file and the raster position.
  hcrpc_pkg::cfg_t              bounds;
  logic [hcrpc_pkg::CoordW-1:0] raster_col;
  logic [hcrpc_pkg::CoordW-1:0] raster_row;
  logic [hcrpc_pkg::CountW-1:0] frame_tally;
  frame_result_t                frame_counts_q[$];

  int          mismatches;
  bit          idle_on;
  int          burst_left;
  logic [15:0] stall_cycle;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #(40_000_000);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Fixed-point BGR to 8-bit HSV with rounded reciprocals of 12 fraction bits.
  function automatic void hsv_convert(input hcrpc_pkg::pix_t p, output int hue,
                                      output int sat, output int val);
    int     b;
    int     g;
    int     r;
    int     mn;
    int     diff;
    int     hnum;
    longint sdiv;
    longint hdiv;
    longint hx;
    b   = int'(p.blue);
    g   = int'(p.green);
    r   = int'(p.red);
    val = (b > g) ? b : g;
    val = (r > val) ? r : val;
    mn  = (b < g) ? b : g;
    mn  = (r < mn) ? r : mn;
    diff = val - mn;
    sdiv = (val == 0) ? 64'sd0 :
           (2 * (longint'(255) << hcrpc_pkg::FixShift) + val) / (2 * val);
    hdiv = (diff == 0) ? 64'sd0 :
           (2 * (longint'(180) << hcrpc_pkg::FixShift) + 6 * diff) / (12 * diff);
    sat  = int'((diff * sdiv + 2048) >>> hcrpc_pkg::FixShift);
    if (val == r) begin
      hnum = g - b;
    end else if (val == g) begin
      hnum = b - r + 2 * diff;
    end else begin
      hnum = r - g + 4 * diff;
    end
    // Arithmetic shift floors a negative product, then negative hue wraps.
    hx = (hnum * hdiv + 2048) >>> hcrpc_pkg::FixShift;
    if (hx < 0) begin
      hx += 180;
    end
    hue = int'(hx);
  endfunction

  // Classify one accepted pixel, tally it and queue the frame count on the last one.
  function automatic void count_pixel(input hcrpc_pkg::pix_t p);
    int hue;
    int sat;
    int val;
    bit hit;
    hsv_convert(p, hue, sat, val);
    hit = hue >= int'(bounds.hue_low) && hue <= int'(bounds.hue_high) &&
          sat >= int'(bounds.saturation_low) && val >= int'(bounds.value_low) &&
          raster_col >= bounds.region_left && raster_col <= bounds.region_right &&
          raster_row >= bounds.region_top && raster_row <= bounds.region_bottom;
    if (hit && frame_tally != hcrpc_pkg::TallyMax) begin
      frame_tally++;
    end
    if (p.frame_end) begin
      frame_counts_q.push_back('{match_count: frame_tally,
                                 detected: int'(frame_tally) >= hcrpc_pkg::DetectThreshold});
      frame_tally = '0;
      raster_col  = '0;
      raster_row  = '0;
    end else if (int'(raster_col) + 1 >= hcrpc_pkg::FrameWidth) begin
      raster_col = '0;
      raster_row = raster_row + 1'b1;
    end else begin
      raster_col = raster_col + 1'b1;
    end
  endfunction

  // Send one pixel word, with bursts and random gaps when idling is on.
  task automatic send_pixel(input hcrpc_pkg::pix_t p);
    int gap;
    if (burst_left == 0) begin
      gap        = (!idle_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix.valid     <= 1'b1;
    pix.blue      <= p.blue;
    pix.green     <= p.green;
    pix.red       <= p.red;
    pix.frame_end <= p.frame_end;
    do begin
      @(posedge clk_i);
    end while (!pix.ready);
    count_pixel(p);
  endtask

  // Register write; unknown indexes leave the shadow untouched.
  task automatic write_reg(input logic [hcrpc_pkg::CfgIdxW-1:0] idx,
                           input logic [hcrpc_pkg::CfgDataW-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      hcrpc_pkg::CFG_HUE_LOW:        bounds.hue_low        = value[hcrpc_pkg::ColorW-1:0];
      hcrpc_pkg::CFG_HUE_HIGH:       bounds.hue_high       = value[hcrpc_pkg::ColorW-1:0];
      hcrpc_pkg::CFG_SATURATION_LOW: bounds.saturation_low = value[hcrpc_pkg::ColorW-1:0];
      hcrpc_pkg::CFG_VALUE_LOW:      bounds.value_low      = value[hcrpc_pkg::ColorW-1:0];
      hcrpc_pkg::CFG_REGION_LEFT:    bounds.region_left    = value;
      hcrpc_pkg::CFG_REGION_RIGHT:   bounds.region_right   = value;
      hcrpc_pkg::CFG_REGION_TOP:     bounds.region_top     = value;
      hcrpc_pkg::CFG_REGION_BOTTOM:  bounds.region_bottom  = value;
      default: ;
    endcase
    // The write channel idles before the next write.
    @(posedge clk_i);
  endtask

  task automatic set_bounds(input int hl, input int hh, input int sl, input int vl,
                            input int rl, input int rr, input int rt, input int rb);
    write_reg(hcrpc_pkg::CFG_HUE_LOW,        hcrpc_pkg::CfgDataW'(hl));
    write_reg(hcrpc_pkg::CFG_HUE_HIGH,       hcrpc_pkg::CfgDataW'(hh));
    write_reg(hcrpc_pkg::CFG_SATURATION_LOW, hcrpc_pkg::CfgDataW'(sl));
    write_reg(hcrpc_pkg::CFG_VALUE_LOW,      hcrpc_pkg::CfgDataW'(vl));
    write_reg(hcrpc_pkg::CFG_REGION_LEFT,    hcrpc_pkg::CfgDataW'(rl));
    write_reg(hcrpc_pkg::CFG_REGION_RIGHT,   hcrpc_pkg::CfgDataW'(rr));
    write_reg(hcrpc_pkg::CFG_REGION_TOP,     hcrpc_pkg::CfgDataW'(rt));
    write_reg(hcrpc_pkg::CFG_REGION_BOTTOM,  hcrpc_pkg::CfgDataW'(rb));
  endtask

  // Wait until every frame count is in, then let the pipe run dry.
  task automatic settle();
    pix.valid <= 1'b0;
    while (frame_counts_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic hcrpc_pkg::pix_t random_pixel();
    hcrpc_pkg::pix_t p;
    int              top;
    int              base;
    p.blue      = 8'($urandom_range(0, 255));
    p.green     = 8'($urandom_range(0, 255));
    p.red       = 8'($urandom_range(0, 255));
    p.frame_end = 1'b0;
    case ($urandom_range(0, 5))
      1: begin
        // Grey pixel.
        p.green = p.blue;
        p.red   = p.blue;
      end
      2: begin
        // One dominant channel.
        top = $urandom_range(0, 2);
        if (top == 0) p.blue = 8'hFF;
        if (top == 1) p.green = 8'hFF;
        if (top == 2) p.red = 8'hFF;
      end
      3: begin
        p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      4: begin
        // Nearly grey, small differences.
        base    = $urandom_range(2, 253);
        p.blue  = 8'(base + $urandom_range(0, 2) - 1);
        p.green = 8'(base + $urandom_range(0, 2) - 1);
        p.red   = 8'(base + $urandom_range(0, 2) - 1);
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_frame(input int len);
    hcrpc_pkg::pix_t p;
    for (int n = 0; n < len; n++) begin
      p           = random_pixel();
      p.frame_end = (n == len - 1);
      send_pixel(p);
    end
  endtask

  // Reset bounds place the region away from row 0, so nothing counts.
  task automatic test_reset_bounds();
    send_frame(8);
    settle();
  endtask

  // Writes to unused indexes must not alias onto a real register.
  task automatic test_unused_index();
    set_bounds(0, 179, 0, 0, 0, 1023, 0, 1023);
    for (int i = FirstUnusedIdx; i < (1 << hcrpc_pkg::CfgIdxW); i++) begin
      write_reg(hcrpc_pkg::CfgIdxW'(i), '1);
    end
    send_frame(12);
    settle();
  endtask

  // Corner colors, one pixel per frame, then all in one frame: black, greys, primaries, negative hue.
  task automatic test_color_corners();
    logic [23:0]     swatches [14];
    hcrpc_pkg::pix_t p;
    swatches = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00,
                 24'hFF0000, 24'h00FFFF, 24'hFFFF00, 24'hFF00FF, 24'h0100FF,
                 24'hFF00FE, 24'h0001FF, 24'hC800FF, 24'hFF0064};
    // Upper data bits are dropped on the 8-bit bounds.
    set_bounds(150, 179, 10'h3FF, 10'h3FF, 0, 1023, 0, 1023);
    foreach (swatches[i]) begin
      {p.blue, p.green, p.red} = swatches[i];
      p.frame_end = 1'b1;
      send_pixel(p);
    end
    settle();
    set_bounds(0, 179, 0, 0, 0, 1023, 0, 1023);
    foreach (swatches[i]) begin
      {p.blue, p.green, p.red} = swatches[i];
      p.frame_end = (i == 13);
      send_pixel(p);
    end
    settle();
  endtask

  // Short frames under random bounds, most regions near the frame origin.
  task automatic test_random_bounds();
    int hl;
    int hh;
    int rl;
    int rr;
    int rt;
    int rb;
    int left;
    int len;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      hl = $urandom_range(0, 179);
      hh = $urandom_range(0, 179);
      if (hl > hh && $urandom_range(0, 2) != 0) begin
        {hl, hh} = {hh, hl};
      end
      if ($urandom_range(0, 5) == 0) hl = $urandom_range(0, 1023);
      if ($urandom_range(0, 5) == 0) hh = $urandom_range(0, 1023);
      if ($urandom_range(0, 4) == 0) begin
        rl = $urandom_range(0, 1023);
        rr = $urandom_range(0, 1023);
        rt = $urandom_range(0, 1023);
        rb = $urandom_range(0, 1023);
      end else begin
        rl = $urandom_range(0, 10);
        rr = $urandom_range(rl, 20);
        rt = 0;
        rb = $urandom_range(0, 3);
      end
      set_bounds(hl, hh,
                 $urandom_range(0, 1) ? $urandom_range(0, 80) : $urandom_range(0, 1023),
                 $urandom_range(0, 1) ? $urandom_range(0, 80) : $urandom_range(0, 1023),
                 rl, rr, rt, rb);
      left = 24;
      while (left > 0) begin
        len = $urandom_range(1, 12);
        len = (len > left) ? left : len;
        send_frame(len);
        left -= len;
      end
      settle();
    end
  endtask

  // Receiver stall pattern: open, random, periodic and mostly closed windows.
  initial begin
    res.ready   <= 1'b0;
    stall_cycle = '0;
    forever begin
      @(posedge clk_i);
      stall_cycle++;
      case (stall_cycle[9:8])
        2'd0: res.ready <= 1'b1;
        2'd1: res.ready <= 1'($urandom_range(0, 1));
        2'd2: res.ready <= (stall_cycle[3:0] >= 4'd5);
        default: res.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Compare each result word with the oldest frame count.
  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (frame_counts_q.size() == 0) begin
        report_mismatch("result word with no frame pending, match_count",
                        int'(res.match_count), -1);
      end else begin
        want = frame_counts_q.pop_front();
        if (res.match_count !== want.match_count) begin
          report_mismatch("match_count", int'(res.match_count), int'(want.match_count));
        end
        if (res.detected !== want.detected) begin
          report_mismatch("detected", int'(res.detected), int'(want.detected));
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    pix.valid     <= 1'b0;
    pix.blue      <= '0;
    pix.green     <= '0;
    pix.red       <= '0;
    pix.frame_end <= 1'b0;
    cfg.valid     <= 1'b0;
    cfg.index     <= '0;
    cfg.data      <= '0;
    bounds        = hcrpc_pkg::CfgReset;
    raster_col    = '0;
    raster_row    = '0;
    frame_tally   = '0;
    mismatches    = 0;
    idle_on       = 1'b1;
    burst_left    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_bounds();
    test_unused_index();
    test_color_corners();
    test_random_bounds();

    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[hsv_color_roi_pixel_counter_unit.f]
hw/rtl/hcrpc_pkg.sv
hw/rtl/hcrpc_if.sv
hw/rtl/hcrpc_front.sv
hw/rtl/hcrpc_queue.sv
hw/rtl/hcrpc_back.sv
hw/rtl/hsv_color_roi_pixel_counter_unit.sv
tb/tb_hsv_color_roi_pixel_counter_unit.sv
